@@ rtl/wsc_pkg.sv @@
// Shared types and constants of the weighted spectrum combiner.
`timescale 1ns / 1ps

package wsc_pkg;

	localparam int unsigned WSC_NUM_BINS = 16384;

	localparam int IDX_W = 14;
	localparam int POW_W = 24;
	localparam int WGT_W = 16;
	localparam int SUM_W = 48;
	localparam int SIG_W = 24;
	localparam int CNT_W = 16;

	localparam int QUEUE_DEPTH = 2;
	localparam int MOD_STEPS   = 6;

	typedef struct packed {
		logic        [IDX_W-1:0] idx;
		logic signed [POW_W-1:0] power;
		logic        [WGT_W-1:0] weight;
	} item_t;

	typedef struct packed {
		logic        [IDX_W-1:0] idx;
		logic signed [POW_W-1:0] power;
		logic        [SIG_W-1:0] sigma;
		logic        [CNT_W-1:0] count;
		logic                    zero;
	} result_t;

	typedef struct packed {
		logic signed [POW_W-1:0] power;
		logic        [SUM_W-1:0] sum;
		logic        [CNT_W-1:0] count;
	} entry_t;

endpackage

@@ rtl/wsc_front.sv @@
// Input stage: takes one item and folds its bin index into the store range.
`timescale 1ns / 1ps

module wsc_front import wsc_pkg::*; #(
	parameter int unsigned NUM_BINS = WSC_NUM_BINS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_push,
	output logic                    in_full,
	input  logic        [IDX_W-1:0] in_index,
	input  logic signed [POW_W-1:0] in_power,
	input  logic        [WGT_W-1:0] in_weight,
	input  logic                    hold,
	input  logic                    q_full,
	output logic                    q_push,
	output item_t                   q_item
);

	typedef enum logic [1:0] {F_IDLE, F_MOD, F_PUSH} fstate_t;

	localparam int MW = 26;
	localparam logic [MW-1:0] BINS_EXT = MW'(NUM_BINS);

	fstate_t      state_q;
	item_t        item_q;
	logic   [2:0] step_q;

	logic [MW-1:0] shifted;
	logic [MW-1:0] idx_ext;
	logic [MW-1:0] idx_sub;
	logic          take;

	always_comb begin
		shifted = BINS_EXT << step_q;
		idx_ext = MW'(item_q.idx);
		take    = idx_ext >= shifted;
		idx_sub = idx_ext - shifted;
	end

	assign in_full = (state_q != F_IDLE) || hold;
	assign q_push  = (state_q == F_PUSH);
	assign q_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
			item_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_push && !in_full) begin
						item_q.idx    <= in_index;
						item_q.power  <= in_power;
						item_q.weight <= in_weight;
						step_q        <= 3'(MOD_STEPS - 1);
						state_q       <= F_MOD;
					end
				end
				F_MOD: begin
					// Restoring reduction, one shifted multiple of the bin count per cycle.
					if (take) begin
						item_q.idx <= idx_sub[IDX_W-1:0];
					end
					if (step_q == 3'd0) begin
						state_q <= F_PUSH;
					end else begin
						step_q <= step_q - 3'd1;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/wsc_queue.sv @@
// Short item queue between the input stage and the update engine.
`timescale 1ns / 1ps

module wsc_queue import wsc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd_en,
	output item_t rd_item,
	output logic  empty
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	item_t         slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          wr;
	logic          rd;

	assign full    = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign wr      = wr_en && !full;
	assign rd      = rd_en && !empty;
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");
`endif

endmodule

@@ rtl/wsc_back.sv @@
// Update engine: bin store, weighted average divider, reciprocal root and result register.
`timescale 1ns / 1ps

module wsc_back import wsc_pkg::*; #(
	parameter int unsigned NUM_BINS = WSC_NUM_BINS
) (
	input  logic    clk,
	input  logic    arst_n,
	output logic    clearing,
	input  logic    q_empty,
	output logic    q_pop,
	input  item_t   q_item,
	output logic    res_empty,
	input  logic    res_pop,
	output result_t res
);

	localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam logic [SUM_W-1:0] SIGMA_LIMIT_SUM = SUM_W'(65536);

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_LOAD, ST_MUL, ST_DIV, ST_SQRT, ST_DONE
	} state_t;

	// Bin store.
	entry_t        mem [NUM_BINS];
	entry_t        rd_data_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_wdata;

	state_t        state_q;
	logic          clearing_q;
	logic [AW-1:0] clr_cnt_q;
	item_t         cur_q;
	entry_t        old_q;
	logic [SUM_W-1:0] new_sum_q;
	logic [31:0]   e_q;
	logic          neg_q;
	logic [24:0]   mag_q;
	logic          zero_q;
	logic [SUM_W-1:0] prem_q;
	logic [24:0]   pnum_q;
	logic [24:0]   pq_q;
	logic [SUM_W-1:0] srem_q;
	logic [SUM_W-1:0] sq_q;
	logic [5:0]    step_q;
	logic [SIG_W-1:0] y_q;
	logic [SIG_W-1:0] bit_q;
	result_t       res_q;
	logic          res_valid_q;

	logic          start;
	logic [31:0]   w2;
	logic [SUM_W:0] sum_ext;
	logic [SUM_W-1:0] new_sum;
	logic [SUM_W-1:0] e_full;
	logic [24:0]   diff;
	logic [56:0]   prod;
	logic [57:0]   num;
	logic [SUM_W:0] ptrial;
	logic [SUM_W:0] strial;
	logic [SUM_W:0] pdiff;
	logic [SUM_W:0] sdiff;
	logic          ptake;
	logic          stake;
	logic [SIG_W-1:0] t_root;
	logic [47:0]   t_sq;
	logic [24:0]   pnew;
	logic [CNT_W-1:0] cnt_new;
	entry_t        upd;

	assign start     = !clearing_q && !q_empty && !res_valid_q;
	assign q_pop     = (state_q == ST_IDLE) && start;
	assign clearing  = clearing_q;
	assign res_empty = !res_valid_q;
	assign res       = res_q;
	assign mem_raddr = AW'(cur_q.idx);

	always_comb begin
		w2      = {16'b0, cur_q.weight} * {16'b0, cur_q.weight};
		sum_ext = {1'b0, rd_data_q.sum} + (SUM_W+1)'(w2);
		new_sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		e_full  = new_sum - rd_data_q.sum;
		diff    = {cur_q.power[POW_W-1], cur_q.power}
			- {rd_data_q.power[POW_W-1], rd_data_q.power};

		prod = mag_q * e_q;
		num  = 58'(prod) + 58'(new_sum_q >> 1);

		ptrial = {prem_q, pnum_q[24]};
		pdiff  = ptrial - {1'b0, new_sum_q};
		ptake  = ptrial >= {1'b0, new_sum_q};
		strial = {srem_q, 1'b0};
		sdiff  = strial - {1'b0, new_sum_q};
		stake  = strial >= {1'b0, new_sum_q};

		t_root = y_q | bit_q;
		t_sq   = t_root * t_root;

		pnew    = neg_q ? ({old_q.power[POW_W-1], old_q.power} - pq_q)
			: ({old_q.power[POW_W-1], old_q.power} + pq_q);
		cnt_new = (old_q.count == '1) ? old_q.count : old_q.count + 1'b1;

		upd.power = pnew[POW_W-1:0];
		upd.sum   = new_sum_q;
		upd.count = cnt_new;

		mem_we    = clearing_q || ((state_q == ST_DONE) && !zero_q);
		mem_waddr = clearing_q ? clr_cnt_q : AW'(cur_q.idx);
		mem_wdata = clearing_q ? '0 : upd;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clearing_q  <= 1'b1;
			clr_cnt_q   <= '0;
			cur_q       <= '0;
			old_q       <= '0;
			new_sum_q   <= '0;
			e_q         <= '0;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			zero_q      <= 1'b0;
			prem_q      <= '0;
			pnum_q      <= '0;
			pq_q        <= '0;
			srem_q      <= '0;
			sq_q        <= '0;
			step_q      <= '0;
			y_q         <= '0;
			bit_q       <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_cnt_q == AW'(NUM_BINS - 1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
				end
			end
			if (res_pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cur_q   <= q_item;
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_LOAD;
				ST_LOAD: begin
					old_q     <= rd_data_q;
					new_sum_q <= new_sum;
					e_q       <= e_full[31:0];
					neg_q     <= diff[24];
					mag_q     <= diff[24] ? 25'(-diff) : diff;
					zero_q    <= (new_sum == '0);
					state_q   <= (new_sum == '0) ? ST_DONE : ST_MUL;
				end
				ST_MUL: begin
					// Rounded quotient needs at most 25 bits, so the top part starts the remainder.
					prem_q  <= SUM_W'(num[57:25]);
					pnum_q  <= num[24:0];
					pq_q    <= '0;
					srem_q  <= SUM_W'(65536);
					sq_q    <= '0;
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (stake) begin
						srem_q <= sdiff[SUM_W-1:0];
					end else begin
						srem_q <= strial[SUM_W-1:0];
					end
					sq_q <= {sq_q[SUM_W-2:0], stake};
					if (step_q < 6'd25) begin
						if (ptake) begin
							prem_q <= pdiff[SUM_W-1:0];
						end else begin
							prem_q <= ptrial[SUM_W-1:0];
						end
						pnum_q <= {pnum_q[23:0], 1'b0};
						pq_q   <= {pq_q[23:0], ptake};
					end
					if (step_q == 6'd47) begin
						y_q     <= '0;
						bit_q   <= {1'b1, {(SIG_W-1){1'b0}}};
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				ST_SQRT: begin
					if (t_sq <= sq_q) begin
						y_q <= t_root;
					end
					bit_q <= bit_q >> 1;
					if (bit_q[0]) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					res_q.idx <= cur_q.idx;
					if (zero_q) begin
						res_q.power <= old_q.power;
						res_q.sigma <= '1;
						res_q.count <= old_q.count;
						res_q.zero  <= 1'b1;
					end else begin
						res_q.power <= pnew[POW_W-1:0];
						res_q.sigma <= (new_sum_q <= SIGMA_LIMIT_SUM) ? '1 : y_q;
						res_q.count <= cnt_new;
						res_q.zero  <= 1'b0;
					end
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> !res_valid_q)
		else $error("result register still occupied at finish");
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> (state_q == ST_IDLE))
		else $error("item in flight during store clearing");
	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> $onehot(bit_q))
		else $error("root trial bit lost");
	a_pop_read: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == ST_READ))
		else $error("queue pop without store read");
`endif

endmodule

@@ rtl/weighted_spectrum_combiner.sv @@
// Top level of the weighted spectrum combiner.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// input     in         push / full        bin_index, bin_power, bin_weight
// result    out        pop / empty        out_index, combined_power, combined_sigma,
//                                         trace_count, zero_weight
//
// Reset clears the bin store one bin per cycle while full is held high. The input stage
// folds the bin index, then holds the item in its push state until the queue has room.
// The update engine goes from taking an item to a waiting result through read and load,
// a 25 by 32 bit product, 48 shared divider steps and 24 square root steps, or from load
// straight to the result for zero weight. A result waits in the output register and the
// engine starts the next item only once it is taken, so a stalled result backs up into full.

module weighted_spectrum_combiner import wsc_pkg::*; #(
	parameter int unsigned NUM_BINS = WSC_NUM_BINS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic        [IDX_W-1:0] bin_index,
	input  logic signed [POW_W-1:0] bin_power,
	input  logic        [WGT_W-1:0] bin_weight,
	output logic                    empty,
	input  logic                    pop,
	output logic        [IDX_W-1:0] out_index,
	output logic signed [POW_W-1:0] combined_power,
	output logic        [SIG_W-1:0] combined_sigma,
	output logic        [CNT_W-1:0] trace_count,
	output logic                    zero_weight
);

	// Between the input stage and the queue.
	logic    fq_push;
	logic    fq_full;
	item_t   fq_item;
	// Between the queue and the engine.
	logic    qb_pop;
	logic    qb_empty;
	item_t   qb_item;
	logic    clearing;
	result_t res;

	wsc_front #(.NUM_BINS(NUM_BINS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_push   (push),
		.in_full   (full),
		.in_index  (bin_index),
		.in_power  (bin_power),
		.in_weight (bin_weight),
		.hold      (clearing),
		.q_full    (fq_full),
		.q_push    (fq_push),
		.q_item    (fq_item)
	);

	wsc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_item (fq_item),
		.full    (fq_full),
		.rd_en   (qb_pop),
		.rd_item (qb_item),
		.empty   (qb_empty)
	);

	wsc_back #(.NUM_BINS(NUM_BINS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.q_empty   (qb_empty),
		.q_pop     (qb_pop),
		.q_item    (qb_item),
		.res_empty (empty),
		.res_pop   (pop),
		.res       (res)
	);

	// Each result transfer presents the register fields directly.
	assign out_index      = res.idx;
	assign combined_power = res.power;
	assign combined_sigma = res.sigma;
	assign trace_count    = res.count;
	assign zero_weight    = res.zero;

endmodule
